FILE: hdl/atpc_pkg.sv
`default_nettype none

package atpc_pkg;

	localparam int LevelsDefault       = 32;
	localparam int MinDbmDefault       = -9;
	localparam int InitialLevelDefault = 14;
	localparam int WindowDefault       = 3;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 8;

	localparam logic [47:0] Day3Ms = 48'd259200000;
	localparam logic [47:0] Day7Ms = 48'd604800000;

	typedef enum logic [2:0] {
		CMD_ACK      = 3'd0,
		CMD_LOST     = 3'd1,
		CMD_SENT     = 3'd2,
		CMD_MATCH    = 3'd3,
		CMD_MAXIMIZE = 3'd4
	} atpc_cmd_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_SNR_FLOOR    = 3'd0,
		REG_RSSI_FLOOR   = 3'd1,
		REG_RSSI_CEILING = 3'd2,
		REG_MIN_PACKETS  = 3'd3,
		REG_ALLOWED_RECO = 3'd4,
		REG_RECO_LOSS    = 3'd5,
		REG_PRIOR_LOSS   = 3'd6
	} atpc_reg_t;

	localparam logic [7:0] SnrFloorReset    = 8'hEC;
	localparam logic [7:0] RssiFloorReset   = 8'h88;
	localparam logic [7:0] RssiCeilingReset = 8'h9C;
	localparam logic [7:0] MinPacketsReset  = 8'd25;
	localparam logic [3:0] AllowedReset     = 4'd2;
	localparam logic [6:0] RecoLossReset    = 7'd5;
	localparam logic [7:0] PriorLossReset   = 8'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SENT,
		ST_LOST,
		ST_RESTART,
		ST_RC0,
		ST_RC1,
		ST_RC2,
		ST_RC3,
		ST_AVG,
		ST_SIG,
		ST_LS1,
		ST_LS2,
		ST_DONE
	} atpc_state_t;

	typedef struct packed {
		logic [3:0]  reco;
		logic [31:0] lost;
		logic [31:0] sent;
	} atpc_stat_t;

	// A level is lossy when it has traffic and either too many losses or a loss
	// ratio of at least one half (with one loss forgiven).
	function automatic logic level_lossy(input atpc_stat_t e, input logic [7:0] limit);
		logic [32:0] twice;
		twice = {e.lost - 32'd1, 1'b0};
		level_lossy = (e.sent != 32'd0) &&
			((e.lost > {24'd0, limit}) || ((e.lost != 32'd0) && (twice >= {1'b0, e.sent})));
	endfunction

endpackage

`default_nettype wire

FILE: hdl/adaptive_tx_power_control_core.sv
`default_nettype none

// Channel  Dir  Bits  Contents (lowest bit first)
// s_*      in   64+3  tdata: rssi, snr, elapsed_ms; tuser: command
// m_*      out  24    tdata: power_dbm, lowest_dbm, power_written, state_restarted
// cfg_*    in   3/8   register write, index and data
//
// One event at a time. Match, maximize or an unknown command goes straight to the
// final state; a packet-sent event, an acknowledgment and a lost acknowledgment take
// longer, set by the read-modify-write passes over the per-level statistics memory
// (one read port, one write port, registered read).
// Reset clears the per-level valid bits at once, so no clearing pass is needed.
// A new event is taken while the previous result waits; a stalled output holds
// the block in its final state until the result register frees.
module adaptive_tx_power_control_core
	import atpc_pkg::*;
#(
	parameter int LEVELS        = LevelsDefault,
	parameter int MIN_DBM       = MinDbmDefault,
	parameter int INITIAL_LEVEL = InitialLevelDefault,
	parameter int WINDOW        = WindowDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [63:0]         s_tdata,   // rssi, snr, elapsed_ms
	input  wire  [2:0]          s_tuser,   // command
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [23:0]         m_tdata,   // power_dbm, lowest_dbm, power_written, state_restarted
	input  wire                 cfg_wen,
	input  wire  [CfgIndexW-1:0] cfg_index,
	input  wire  [CfgDataW-1:0] cfg_wdata
);

	localparam int LW = $clog2(LEVELS);
	localparam int InitLvl = (INITIAL_LEVEL < LEVELS) ? INITIAL_LEVEL : LEVELS - 1;
	localparam logic [LW-1:0] TopLvl  = LW'(LEVELS - 1);
	localparam logic [LW-1:0] InitL   = LW'(InitLvl);
	localparam logic [1:0]    WinFull = 2'(WINDOW);
	localparam int STW = $bits(atpc_stat_t);

	atpc_state_t state_q, state_nx;

	logic [7:0] snr_floor_q, rssi_floor_q, rssi_ceil_q, min_pkts_q, prior_loss_q;
	logic [3:0] allowed_q;
	logic [6:0] reco_loss_q;

	logic [2:0]         cmd_q;
	logic signed [7:0]  snr_q;
	logic [47:0]        now_q, prev_q;
	logic [LW-1:0]      cur_q, low_q, step_q;
	logic [1:0]         sc_q;
	logic signed [7:0]  hist_rssi_q [WINDOW];
	logic signed [7:0]  hist_snr_q  [WINDOW];
	logic [LEVELS-1:0]  vld_q;
	atpc_stat_t         a_q, b_q;
	logic [38:0]        prodl_q, prods_q;
	logic signed [7:0]  ar_q, as_q;
	logic               written_q, restarted_q;

	logic [STW-1:0] mem [LEVELS];
	logic [STW-1:0] rd_q;
	logic           rd_vld_q;
	logic           mem_we;
	logic [LW-1:0]  mem_waddr, mem_raddr;
	atpc_stat_t     mem_wdata, ent;

	logic           accept, out_free, restart_hit, must_inc, should_inc, try_dec, full;
	logic           rc_cond;
	logic signed [7:0] avg_rssi, avg_snr;
	logic signed [8:0] diff;
	logic [15:0]    m10;
	logic [6:0]     step7;
	logic [LW-1:0]  stepc;
	logic [31:0]    lost_inc, sent_inc;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;
	assign ent      = rd_vld_q ? atpc_stat_t'(rd_q) : '0;
	assign full     = (sc_q >= WinFull);
	assign lost_inc = ent.lost + 32'd1;
	assign sent_inc = ent.sent + 32'd1;

	assign restart_hit = (cur_q == TopLvl) &&
		(((prev_q < Day3Ms) && (now_q > Day3Ms)) || ((prev_q < Day7Ms) && (now_q > Day7Ms)));

	assign rc_cond = (a_q.sent > {24'd0, min_pkts_q}) && (b_q.reco < allowed_q) &&
		(prodl_q < prods_q) && (b_q.lost > {24'd0, prior_loss_q});

	// Window averages, truncated toward zero; division by three is a reciprocal
	// multiply that stays exact over the range of a three-sample sum.
	function automatic logic signed [7:0] win_avg(input logic signed [9:0] sum);
		logic [9:0]  mag;
		logic [18:0] m3;
		logic [7:0]  q;
		mag = sum[9] ? 10'(-sum) : sum;
		m3  = 19'(mag) * 19'd171;
		if (WINDOW == 3) begin
			q = m3[16:9];
		end else if (WINDOW == 2) begin
			q = mag[8:1];
		end else begin
			q = mag[7:0];
		end
		win_avg = sum[9] ? 8'(-q) : q;
	endfunction

	always_comb begin
		logic signed [9:0] sr, ss;
		sr = '0;
		ss = '0;
		for (int i = 0; i < WINDOW; i++) begin
			sr = sr + 10'(hist_rssi_q[i]);
			ss = ss + 10'(hist_snr_q[i]);
		end
		avg_rssi = win_avg(sr);
		avg_snr  = win_avg(ss);
	end

	// Decrease step: one plus twice the tenths of the margin above the ceiling, capped at the current level.
	assign diff  = 9'(ar_q) - 9'($signed(rssi_ceil_q));
	assign m10   = 16'(diff[7:0]) * 16'd205;
	assign step7 = 7'({m10[15:11], 1'b0}) + 7'd1;
	assign stepc = (step7 > 7'(cur_q)) ? cur_q : step7[LW-1:0];

	assign must_inc   = (cmd_q == CMD_ACK) && (snr_q < $signed(snr_floor_q));
	assign should_inc = full && ((as_q < $signed(snr_floor_q)) || (ar_q < $signed(rssi_floor_q)));
	assign try_dec    = full && !should_inc && (ar_q > $signed(rssi_ceil_q));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						CMD_ACK:  state_nx = ST_RESTART;
						CMD_LOST: state_nx = ST_LOST;
						CMD_SENT: state_nx = ST_SENT;
						default:  state_nx = ST_DONE;
					endcase
				end
			end
			ST_SENT:    state_nx = ST_DONE;
			ST_LOST:    state_nx = ST_RESTART;
			ST_RESTART: state_nx = ST_RC0;
			ST_RC0:     state_nx = (cur_q == '0) ? ST_AVG : ST_RC1;
			ST_RC1:     state_nx = ST_RC2;
			ST_RC2:     state_nx = ST_RC3;
			ST_RC3:     state_nx = ST_AVG;
			ST_AVG:     state_nx = ST_SIG;
			ST_SIG: begin
				if ((cur_q < TopLvl) && (must_inc || should_inc)) begin
					state_nx = ST_DONE;
				end else if ((cur_q != '0) && try_dec) begin
					state_nx = ST_LS1;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_LS1: begin
				if (level_lossy(ent, prior_loss_q) && (step_q != LW'(1))) begin
					state_nx = ST_LS2;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_LS2:  state_nx = ST_DONE;
			ST_DONE: state_nx = out_free ? ST_IDLE : ST_DONE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = ent;
		mem_raddr = cur_q;
		case (state_q)
			ST_SENT: begin
				mem_we = 1'b1;
				if (sent_inc == 32'd0) begin
					mem_wdata.sent = 32'd1;
					mem_wdata.lost = 32'd0;
				end else begin
					mem_wdata.sent = sent_inc;
				end
			end
			ST_LOST: begin
				mem_we = 1'b1;
				mem_wdata.lost = lost_inc;
			end
			ST_RC1: mem_raddr = cur_q - LW'(1);
			ST_RC3: begin
				mem_we    = rc_cond;
				mem_waddr = cur_q - LW'(1);
				mem_wdata = '{reco: b_q.reco + 4'd1, lost: 32'd0, sent: 32'd0};
			end
			ST_SIG: mem_raddr = cur_q - stepc;
			ST_LS1: mem_raddr = cur_q - LW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_RC1: a_q <= ent;
			ST_RC2: begin
				b_q     <= ent;
				prodl_q <= 39'(a_q.lost) * 39'd100;
				prods_q <= 39'(a_q.sent) * 39'(reco_loss_q);
			end
			ST_AVG: begin
				ar_q <= avg_rssi;
				as_q <= avg_snr;
			end
			default: ;
		endcase
		if (accept) begin
			cmd_q <= s_tuser;
			snr_q <= $signed(s_tdata[15:8]);
			now_q <= s_tdata[63:16];
			if (s_tuser == CMD_ACK) begin
				if (sc_q < WinFull) begin
					// Until the window fills, samples land in order of arrival.
					for (int i = 0; i < WINDOW; i++) begin
						if (sc_q == 2'(i)) begin
							hist_rssi_q[i] <= $signed(s_tdata[7:0]);
							hist_snr_q[i]  <= $signed(s_tdata[15:8]);
						end
					end
				end else begin
					hist_rssi_q[0] <= $signed(s_tdata[7:0]);
					hist_snr_q[0]  <= $signed(s_tdata[15:8]);
					for (int i = 1; i < WINDOW; i++) begin
						hist_rssi_q[i] <= hist_rssi_q[i-1];
						hist_snr_q[i]  <= hist_snr_q[i-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			snr_floor_q  <= SnrFloorReset;
			rssi_floor_q <= RssiFloorReset;
			rssi_ceil_q  <= RssiCeilingReset;
			min_pkts_q   <= MinPacketsReset;
			allowed_q    <= AllowedReset;
			reco_loss_q  <= RecoLossReset;
			prior_loss_q <= PriorLossReset;
			cur_q        <= InitL;
			low_q        <= InitL;
			step_q       <= '0;
			sc_q         <= '0;
			prev_q       <= '0;
			vld_q        <= '0;
			rd_vld_q     <= 1'b0;
			written_q    <= 1'b0;
			restarted_q  <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
		end else begin
			state_q  <= state_nx;
			rd_vld_q <= vld_q[mem_raddr];
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (cfg_wen) begin
				case (cfg_index)
					REG_SNR_FLOOR:    snr_floor_q  <= cfg_wdata;
					REG_RSSI_FLOOR:   rssi_floor_q <= cfg_wdata;
					REG_RSSI_CEILING: rssi_ceil_q  <= cfg_wdata;
					REG_MIN_PACKETS:  min_pkts_q   <= cfg_wdata;
					REG_ALLOWED_RECO: allowed_q    <= cfg_wdata[3:0];
					REG_RECO_LOSS:    reco_loss_q  <= cfg_wdata[6:0];
					REG_PRIOR_LOSS:   prior_loss_q <= cfg_wdata;
					default: ;
				endcase
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						written_q   <= (s_tuser == CMD_MATCH);
						restarted_q <= 1'b0;
						if (s_tuser == CMD_ACK && sc_q < WinFull) begin
							sc_q <= sc_q + 2'd1;
						end
						if ((s_tuser == CMD_MATCH) || (s_tuser == CMD_MAXIMIZE)) begin
							cur_q <= TopLvl;
						end
					end
				end
				ST_LOST: begin
					if ((lost_inc != 32'd1) && (cur_q < TopLvl)) begin
						cur_q     <= cur_q + LW'(1);
						sc_q      <= '0;
						written_q <= 1'b1;
					end
				end
				ST_RESTART: begin
					prev_q <= now_q;
					if (restart_hit) begin
						cur_q       <= InitL;
						low_q       <= InitL;
						sc_q        <= '0;
						vld_q       <= '0;
						restarted_q <= 1'b1;
					end
				end
				ST_SIG: begin
					step_q <= stepc;
					if ((cur_q < TopLvl) && (must_inc || should_inc)) begin
						cur_q     <= cur_q + LW'(1);
						sc_q      <= '0;
						written_q <= 1'b1;
					end
				end
				ST_LS1: begin
					if (!level_lossy(ent, prior_loss_q)) begin
						cur_q     <= cur_q - step_q;
						sc_q      <= '0;
						written_q <= 1'b1;
						if ((cur_q - step_q) < low_q) begin
							low_q <= cur_q - step_q;
						end
					end
				end
				ST_LS2: begin
					if (!level_lossy(ent, prior_loss_q)) begin
						cur_q     <= cur_q - LW'(1);
						sc_q      <= '0;
						written_q <= 1'b1;
						if ((cur_q - LW'(1)) < low_q) begin
							low_q <= cur_q - LW'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata <= {6'd0, restarted_q, written_q,
							8'(low_q) + 8'(MIN_DBM), 8'(cur_q) + 8'(MIN_DBM)};
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire
